// ===== design/test_and_set_lock_bank_unit_defines.svh =====
// Assertion macros for the test-and-set lock bank.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TEST_AND_SET_LOCK_BANK_UNIT_DEFINES_SVH
`define TEST_AND_SET_LOCK_BANK_UNIT_DEFINES_SVH

// same-cycle implication
`define TSLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tslb_pkg.sv =====
// Shared constants, codes and types of the test-and-set lock bank.
// No dependencies.
`timescale 1ns / 1ps

package tslb_pkg;

    localparam int NUM_LOCKS  = 64;
    localparam int WORD_BYTES = 4;     // power of two
    localparam int WORD_SHIFT = $clog2(WORD_BYTES);
    localparam int IDX_W      = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam logic [32:0] SEG_BYTES = 33'(NUM_LOCKS * WORD_BYTES);

    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int SRC_W  = 8;
    localparam int TRD_W  = 4;
    localparam int PKT_W  = 4;

    // request operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;

    typedef enum logic [1:0] {
        STATUS_READ  = 2'd0,
        STATUS_WRITE = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic load;    // capture a request and update the lock array
    } tslb_ctrl_t;

endpackage

// ===== design/tslb_if.sv =====
// Request and response channel interfaces of the lock bank.
// Depends on tslb_pkg.
`timescale 1ns / 1ps

interface tslb_cmd_if;
    import tslb_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [ADDR_W-1:0]   address;
    logic                end_of_packet;
    logic [SRC_W-1:0]    source_id;
    logic [TRD_W-1:0]    thread_id;
    logic [PKT_W-1:0]    packet_id;

    modport source (output valid, op, address, end_of_packet, source_id, thread_id,
                    packet_id, input ready);
    modport sink   (input valid, op, address, end_of_packet, source_id, thread_id,
                    packet_id, output ready);
endinterface

interface tslb_rsp_if;
    import tslb_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [DATA_W-1:0]   read_data;
    logic [SRC_W-1:0]    resp_source_id;
    logic [TRD_W-1:0]    resp_thread_id;
    logic [PKT_W-1:0]    resp_packet_id;
    logic                resp_end_of_packet;

    modport source (output valid, status, read_data, resp_source_id, resp_thread_id,
                    resp_packet_id, resp_end_of_packet, input ready);
    modport sink   (input valid, status, read_data, resp_source_id, resp_thread_id,
                    resp_packet_id, resp_end_of_packet, output ready);
endinterface

// ===== design/tslb_ctrl.sv =====
// Controller of the lock bank: tracks the response register and
// issues the load command. Depends on tslb_pkg.
`timescale 1ns / 1ps

module tslb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output tslb_pkg::tslb_ctrl_t ctrl
);
    import tslb_pkg::*;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // a new request may enter while the held response leaves
    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign out_valid = (state_reg == ST_FULL);
    assign ctrl.load = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (ctrl.load)
                    state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (!ctrl.load && out_ready)
                    state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/tslb_datapath.sv =====
// Datapath of the lock bank: base register, lock flags, address decode
// and response register. Depends on tslb_pkg.
`timescale 1ns / 1ps

module tslb_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tslb_pkg::ADDR_W-1:0] cfg_wdata,
    input  tslb_pkg::tslb_ctrl_t        ctrl,
    input  logic [1:0]                  op,
    input  logic [tslb_pkg::ADDR_W-1:0] address,
    input  logic                        end_of_packet,
    input  logic [tslb_pkg::SRC_W-1:0]  source_id,
    input  logic [tslb_pkg::TRD_W-1:0]  thread_id,
    input  logic [tslb_pkg::PKT_W-1:0]  packet_id,
    output tslb_pkg::status_t           status,
    output logic [tslb_pkg::DATA_W-1:0] read_data,
    output logic [tslb_pkg::SRC_W-1:0]  resp_source_id,
    output logic [tslb_pkg::TRD_W-1:0]  resp_thread_id,
    output logic [tslb_pkg::PKT_W-1:0]  resp_packet_id,
    output logic                        resp_end_of_packet
);
    import tslb_pkg::*;

    logic [ADDR_W-1:0]    base_reg;
    logic [NUM_LOCKS-1:0] lock_reg;
    logic [NUM_LOCKS-1:0] lock_next;

    status_t              status_reg, status_next;
    logic [DATA_W-1:0]    data_reg, data_next;
    logic [SRC_W-1:0]     src_reg;
    logic [TRD_W-1:0]     trd_reg;
    logic [PKT_W-1:0]     pkt_reg;
    logic                 eop_reg;

    logic [ADDR_W-1:0]    offset;
    logic                 hit;
    logic [IDX_W-1:0]     idx;
    logic                 held;

    // offset wraps modulo 2^32, so a segment may wrap past the top
    assign offset = address - base_reg;
    assign hit    = end_of_packet && ({1'b0, offset} < SEG_BYTES);
    assign idx    = IDX_W'(offset >> WORD_SHIFT);
    assign held   = lock_reg[idx];

    always_comb
    begin
        lock_next   = lock_reg;
        status_next = STATUS_ERROR;
        data_next   = '0;
        if (hit)
        begin
            priority if (op == OP_READ)
            begin
                data_next      = held ? '1 : '0;
                lock_next[idx] = 1'b1;
                status_next    = STATUS_READ;
            end
            else if (op == OP_WRITE)
            begin
                lock_next[idx] = 1'b0;
                status_next    = STATUS_WRITE;
            end
            else
            begin
                status_next = STATUS_ERROR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            lock_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                base_reg <= cfg_wdata;
            if (ctrl.load)
                lock_reg <= lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            src_reg    <= source_id;
            trd_reg    <= thread_id;
            pkt_reg    <= packet_id;
            eop_reg    <= end_of_packet;
        end
    end

    assign status             = status_reg;
    assign read_data          = data_reg;
    assign resp_source_id     = src_reg;
    assign resp_thread_id     = trd_reg;
    assign resp_packet_id     = pkt_reg;
    assign resp_end_of_packet = eop_reg;

endmodule

// ===== design/test_and_set_lock_bank_unit.sv =====
// Test-and-set lock bank: top level joining controller and datapath.
// Depends on tslb_pkg, tslb_if, tslb_ctrl, tslb_datapath and the defines header.
//
// Usage:
//   cmd  - request channel (valid/ready). op 0 is test-and-set, op 1 release.
//          Each request addresses one lock word at base + index * WORD_BYTES.
//   rsp  - response channel (valid/ready), exactly one response per request,
//          echoing source/thread/packet ids and end-of-packet.
//   cfg_we / cfg_wdata - writes the segment base address; write only while
//          no request is in flight.
// A response is registered and appears in the cycle after its request is taken.
// Throughput: one request per cycle while rsp is not stalled; the lock flags are
//   updated by a single read-modify-write in the cycle a request is taken.
// A request that is not single-word, misses the segment or has any other op
//   gets an error response and leaves the locks untouched.
// Reset frees every lock and clears the base address to 0; no clearing pass.
// When the receiver stalls, the response register holds its request and cmd
//   ready drops; ready returns in the cycle the response is taken.
`timescale 1ns / 1ps

`include "test_and_set_lock_bank_unit_defines.svh"

module test_and_set_lock_bank_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tslb_pkg::ADDR_W-1:0] cfg_wdata,
    tslb_cmd_if.sink                    cmd,
    tslb_rsp_if.source                  rsp
);
    import tslb_pkg::*;

    tslb_ctrl_t ctrl;

    tslb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    tslb_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .ctrl               (ctrl),
        .op                 (cmd.op),
        .address            (cmd.address),
        .end_of_packet      (cmd.end_of_packet),
        .source_id          (cmd.source_id),
        .thread_id          (cmd.thread_id),
        .packet_id          (cmd.packet_id),
        .status             (rsp.status),
        .read_data          (rsp.read_data),
        .resp_source_id     (rsp.resp_source_id),
        .resp_thread_id     (rsp.resp_thread_id),
        .resp_packet_id     (rsp.resp_packet_id),
        .resp_end_of_packet (rsp.resp_end_of_packet)
    );

    `TSLB_ASSERT_NEXT(a_take_gives_rsp, ctrl.load, rsp.valid, "request taken but no response")
    `TSLB_ASSERT_NEXT(a_multiword_err, ctrl.load && !cmd.end_of_packet,
                      rsp.status == STATUS_ERROR, "multi-word request not rejected")
    `TSLB_ASSERT_NOW(a_data_only_read, rsp.valid && rsp.status != STATUS_READ,
                     rsp.read_data == '0, "nonzero data on write or error response")
    `TSLB_ASSERT_NOW(a_data_all_or_none, rsp.valid && rsp.read_data != '0,
                     rsp.read_data == '1, "read data neither zero nor all ones")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the test-and-set lock bank (test_and_set_lock_bank_unit).
// Drives requests and checks every response against a cycle-free model of the lock array.
// Depends on tslb_pkg and the tslb_cmd_if / tslb_rsp_if interfaces.
`timescale 1ns / 1ps

module tb_top;
    import tslb_pkg::*;

    localparam int          CLK_PERIOD      = 12;
    localparam int          RESET_CYCLES    = 5;
    localparam int          DRAIN_CYCLES    = 3;
    localparam int          HOLD_OFF_CYCLES = 200;
    localparam int unsigned QUIET_LIMIT     = 2000;
    localparam int          MAX_REPORTS     = 100;

    // codes the package leaves unnamed: both must get an error response
    localparam logic [1:0] OP_OTHER  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
        logic              end_of_packet;
        logic [SRC_W-1:0]  source_id;
        logic [TRD_W-1:0]  thread_id;
        logic [PKT_W-1:0]  packet_id;
    } lock_request_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] read_data;
        logic [SRC_W-1:0]  source_id;
        logic [TRD_W-1:0]  thread_id;
        logic [PKT_W-1:0]  packet_id;
        logic              end_of_packet;
    } lock_response_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_wdata;

    tslb_cmd_if cmd_if ();
    tslb_rsp_if rsp_if ();

    test_and_set_lock_bank_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_if),
        .rsp       (rsp_if)
    );

    // model state
    logic [NUM_LOCKS-1:0] lock_held = '0;
    logic [ADDR_W-1:0]    lock_base = '0;
    lock_response_t       pending_responses[$];

    int unsigned mismatch_count   = 0;
    int unsigned source_idle_pct  = 0;
    int unsigned sink_idle_pct    = 0;
    bit          hold_off_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic lock_response_t predict_lock_response(input lock_request_t req);
        lock_response_t    rsp;
        logic [ADDR_W-1:0] offset;
        logic [IDX_W-1:0]  idx;
        rsp.status        = STATUS_ERROR;
        rsp.read_data     = '0;
        rsp.source_id     = req.source_id;
        rsp.thread_id     = req.thread_id;
        rsp.packet_id     = req.packet_id;
        rsp.end_of_packet = req.end_of_packet;
        offset            = req.address - lock_base;   // wraps modulo 2^32
        if (req.end_of_packet && ({1'b0, offset} < SEG_BYTES))
        begin
            idx = IDX_W'(offset / WORD_BYTES);
            if (req.op == OP_READ)
            begin
                rsp.read_data  = lock_held[idx] ? '1 : '0;
                lock_held[idx] = 1'b1;
                rsp.status     = STATUS_READ;
            end
            else if (req.op == OP_WRITE)
            begin
                lock_held[idx] = 1'b0;
                rsp.status     = STATUS_WRITE;
            end
        end
        return rsp;
    endfunction

    // Offer one request; returns in the time step it is taken, valid still high.
    task automatic send_request(input lock_request_t req);
        int unsigned gap;
        if (source_idle_pct != 0 && $urandom_range(0, 99) < source_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.op            <= req.op;
        cmd_if.address       <= req.address;
        cmd_if.end_of_packet <= req.end_of_packet;
        cmd_if.source_id     <= req.source_id;
        cmd_if.thread_id     <= req.thread_id;
        cmd_if.packet_id     <= req.packet_id;
        do @(posedge clk); while (cmd_if.ready !== 1'b1);
        pending_responses.push_back(predict_lock_response(req));
    endtask

    task automatic send_cmd(input logic [1:0] op, input logic [ADDR_W-1:0] address,
                            input logic eop);
        lock_request_t req;
        req.op            = op;
        req.address       = address;
        req.end_of_packet = eop;
        req.source_id     = SRC_W'($urandom);
        req.thread_id     = TRD_W'($urandom);
        req.packet_id     = PKT_W'($urandom);
        send_request(req);
    endtask

    // Must be called in the step of the last accept.
    task automatic drain_responses();
        cmd_if.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_lock_base(input logic [ADDR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        lock_base = value;
        cfg_we    <= 1'b0;
    endtask

    function automatic lock_request_t random_request();
        lock_request_t req;
        int unsigned   kind;
        int unsigned   idx;
        kind              = $urandom_range(0, 99);
        // a few hot locks give plenty of contention
        idx               = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, NUM_LOCKS - 1);
        req.op            = ($urandom_range(0, 99) < 60) ? OP_READ : OP_WRITE;
        req.address       = lock_base + idx * WORD_BYTES + $urandom_range(0, WORD_BYTES - 1);
        req.end_of_packet = 1'b1;
        req.source_id     = SRC_W'($urandom);
        req.thread_id     = TRD_W'($urandom);
        req.packet_id     = PKT_W'($urandom);
        if (kind < 8)
            req.address = $urandom;
        else if (kind < 12)
            req.address = lock_base + SEG_BYTES[ADDR_W-1:0] + $urandom_range(0, 7);
        else if (kind < 16)
            req.address = lock_base - $urandom_range(1, 8);
        else if (kind < 20)
            req.end_of_packet = 1'b0;
        else if (kind < 25)
            req.op = $urandom_range(0, 1) ? OP_OTHER : OP_UNUSED;
        return req;
    endfunction

    task automatic test_directed_locks();
        write_lock_base('0);
        send_request('{op: OP_READ, address: 32'h0, end_of_packet: 1'b1,
                       source_id: 8'h00, thread_id: 4'h0, packet_id: 4'h0});
        send_request('{op: OP_READ, address: 32'h3, end_of_packet: 1'b1,
                       source_id: 8'hFF, thread_id: 4'hF, packet_id: 4'hF});
        send_cmd(OP_WRITE, 32'h0, 1'b1);
        send_cmd(OP_READ, 32'h0, 1'b1);
        send_cmd(OP_READ, 32'd252, 1'b1);       // last lock
        send_cmd(OP_READ, 32'd255, 1'b1);
        send_cmd(OP_READ, 32'd256, 1'b1);       // first byte past the segment
        send_cmd(OP_WRITE, 32'hFFFF_FFFF, 1'b1);
        // multi-word packets leave the lock alone
        send_cmd(OP_READ, 32'h4, 1'b0);
        send_cmd(OP_READ, 32'h4, 1'b1);
        send_cmd(OP_WRITE, 32'h4, 1'b0);
        send_cmd(OP_READ, 32'h4, 1'b1);
        send_cmd(OP_OTHER, 32'h8, 1'b1);
        send_cmd(OP_UNUSED, 32'h8, 1'b1);
        send_cmd(OP_READ, 32'h8, 1'b1);
        send_cmd(OP_WRITE, 32'h14, 1'b1);       // release of a free lock
        drain_responses();
    endtask

    task automatic test_segment_wrap();
        write_lock_base(32'hFFFF_FF80);         // segment wraps past the top
        send_cmd(OP_READ, 32'hFFFF_FF80, 1'b1);
        send_cmd(OP_READ, 32'h0000_007C, 1'b1);
        send_cmd(OP_READ, 32'h0000_0080, 1'b1);
        send_cmd(OP_READ, 32'hFFFF_FF7F, 1'b1);
        send_cmd(OP_WRITE, 32'h0000_007F, 1'b1);
        send_cmd(OP_READ, 32'h0000_007C, 1'b1);
        drain_responses();
        write_lock_base(32'hFFFF_FFFF);
        send_cmd(OP_READ, 32'hFFFF_FFFF, 1'b1);
        send_cmd(OP_READ, 32'h0000_0000, 1'b1);
        send_cmd(OP_READ, 32'h0000_00FE, 1'b1);
        send_cmd(OP_READ, 32'h0000_00FF, 1'b1);
        drain_responses();
    endtask

    task automatic test_response_backpressure();
        source_idle_pct  = 0;
        sink_idle_pct    = 0;
        hold_off_request = 1'b1;
        repeat (40) send_request(random_request());
        drain_responses();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            source_idle_pct = $urandom_range(10, 50);
            sink_idle_pct   = $urandom_range(10, 50);
            if (phase == 0)
                write_lock_base('0);
            else if (phase == 1)
                write_lock_base($urandom);
            else
                write_lock_base($urandom & ~32'(WORD_BYTES - 1));
            repeat (200) send_request(random_request());
            drain_responses();
        end
    endtask

    task automatic test_full_rate();
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        write_lock_base($urandom & ~32'(WORD_BYTES - 1));
        repeat (200) send_request(random_request());
        drain_responses();
    endtask

    initial
    begin : stimulus
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        cmd_if.valid         <= 1'b0;
        cmd_if.op            <= OP_READ;
        cmd_if.address       <= '0;
        cmd_if.end_of_packet <= 1'b0;
        cmd_if.source_id     <= '0;
        cmd_if.thread_id     <= '0;
        cmd_if.packet_id     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_locks();
        test_segment_wrap();
        test_response_backpressure();
        test_random_traffic();
        test_full_rate();

        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : response_sink
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
                rsp_if.ready <= 1'b1;
            end
            else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct)
            begin
                rsp_if.ready <= 1'b0;
                stall = $urandom_range(1, 10);
                repeat (stall) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : response_check
        lock_response_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: response with no request pending, expected none, got status %0d",
                             $time, rsp_if.status);
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("status", DATA_W'(want.status), DATA_W'(rsp_if.status));
                check_field("read_data", want.read_data, rsp_if.read_data);
                check_field("resp_source_id", DATA_W'(want.source_id),
                            DATA_W'(rsp_if.resp_source_id));
                check_field("resp_thread_id", DATA_W'(want.thread_id),
                            DATA_W'(rsp_if.resp_thread_id));
                check_field("resp_packet_id", DATA_W'(want.packet_id),
                            DATA_W'(rsp_if.resp_packet_id));
                check_field("resp_end_of_packet", DATA_W'(want.end_of_packet),
                            DATA_W'(rsp_if.resp_end_of_packet));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
                || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no request or response moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== test_and_set_lock_bank_unit.f =====
+incdir+design
design/tslb_pkg.sv
design/tslb_if.sv
design/tslb_ctrl.sv
design/tslb_datapath.sv
design/test_and_set_lock_bank_unit.sv
tb/tb_top.sv
